/* rtl/lcsp_pkg.sv */
package lcsp_pkg;

	// request type codes on the input channel
	localparam logic [1:0] REQ_CHAR = 2'd0;
	localparam logic [1:0] REQ_BTN1 = 2'd1;
	localparam logic [1:0] REQ_BTN2 = 2'd2;

	// character codes
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// queue between classifier and executor
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// keyword table, order led1, led2, off, toggle
	localparam int NKW     = 4;
	localparam int KW_MAXL = 6;
	localparam int KW_LED1   = 0;
	localparam int KW_LED2   = 1;
	localparam int KW_OFF    = 2;
	localparam int KW_TOGGLE = 3;
	localparam logic [7:0] KW_TEXT [0:NKW-1][0:KW_MAXL-1] = '{
		'{"l", "e", "d", "1", 8'd0, 8'd0},
		'{"l", "e", "d", "2", 8'd0, 8'd0},
		'{"o", "f", "f", 8'd0, 8'd0, 8'd0},
		'{"t", "o", "g", "g", "l", "e"}
	};
	localparam logic [2:0] KW_LEN [0:NKW-1] = '{3'd4, 3'd4, 3'd3, 3'd6};
	localparam logic [2:0] POS_MAX = 3'd7;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_PLUS,
		CLS_MINUS,
		CLS_CR,
		CLS_OTHER,
		CLS_BTN1,
		CLS_BTN2
	} item_cls_t;

	typedef enum logic [2:0] {
		KIND_UNKNOWN = 3'd0,
		KIND_LED1    = 3'd1,
		KIND_LED2    = 3'd2,
		KIND_OFF     = 3'd3,
		KIND_TOGGLE  = 3'd4,
		KIND_EXPR    = 3'd5,
		KIND_BUTTON  = 3'd6
	} cmd_kind_t;

	typedef struct packed {
		item_cls_t   cls;
		logic [7:0]  code;
	} item_t;

	// handshake between queue and executor
	typedef struct packed {
		logic  avail;
		item_t item;
	} q_head_t;

endpackage

/* rtl/lcsp_front.sv */
module lcsp_front (
	input  logic               req_valid,
	input  logic [1:0]         req_type,
	input  logic [7:0]         char_code,
	input  logic               q_full,
	output logic               req_stall,
	output logic               push,
	output lcsp_pkg::item_t    push_item
);

	assign req_stall = q_full;

	always_comb begin
		push_item.code = char_code;
		push_item.cls  = lcsp_pkg::CLS_OTHER;
		push           = req_valid && !q_full;
		case (req_type)
			lcsp_pkg::REQ_CHAR: begin
				if (char_code == lcsp_pkg::CHAR_CR)
					push_item.cls = lcsp_pkg::CLS_CR;
				else if (char_code >= lcsp_pkg::CHAR_ZERO && char_code <= lcsp_pkg::CHAR_NINE)
					push_item.cls = lcsp_pkg::CLS_DIGIT;
				else if (char_code == lcsp_pkg::CHAR_PLUS)
					push_item.cls = lcsp_pkg::CLS_PLUS;
				else if (char_code == lcsp_pkg::CHAR_MINUS)
					push_item.cls = lcsp_pkg::CLS_MINUS;
				else
					push_item.cls = lcsp_pkg::CLS_OTHER;
			end
			lcsp_pkg::REQ_BTN1: push_item.cls = lcsp_pkg::CLS_BTN1;
			lcsp_pkg::REQ_BTN2: push_item.cls = lcsp_pkg::CLS_BTN2;
			default: begin
				// drop the unused request type
				push = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/lcsp_queue.sv */
module lcsp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lcsp_pkg::item_t    push_item,
	input  logic               pop,
	output logic               full,
	output lcsp_pkg::q_head_t  head
);

	lcsp_pkg::item_t          mem_q [0:lcsp_pkg::QDEPTH-1];
	logic [lcsp_pkg::QAW-1:0] wr_ptr_q;
	logic [lcsp_pkg::QAW-1:0] rd_ptr_q;
	logic [lcsp_pkg::QAW:0]   count_q;

	assign full       = (count_q == (lcsp_pkg::QAW+1)'(lcsp_pkg::QDEPTH));
	assign head.avail = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/lcsp_back.sv */
module lcsp_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lcsp_pkg::q_head_t        head,
	output logic                     pop,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [2:0]               command_kind,
	output logic signed [31:0]       sum_value,
	output logic                     green_on,
	output logic                     red_on
);

	logic                    green_q, red_q;
	logic [2:0]              pos_q;
	logic [lcsp_pkg::NKW-1:0] alive_q;
	logic                    digit_q, bad_q, minus_q;
	logic [VALUE_WIDTH-1:0]  num_q, sum_q;
	logic                    res_valid_q;
	lcsp_pkg::cmd_kind_t     kind_q;
	logic [31:0]             sumv_q;

	lcsp_pkg::item_cls_t     cls;
	logic [7:0]              code;
	logic                    is_result;
	logic [VALUE_WIDTH-1:0]  close_val;
	logic [VALUE_WIDTH-1:0]  num_next;
	logic [31:0]             close32;
	logic [lcsp_pkg::NKW-1:0] mismatch;
	lcsp_pkg::cmd_kind_t     kw_kind;
	lcsp_pkg::cmd_kind_t     kind_n;
	logic [31:0]             sumv_n;
	logic                    green_n, red_n;

	assign cls  = head.item.cls;
	assign code = head.item.code;

	assign is_result = (cls == lcsp_pkg::CLS_CR) || (cls == lcsp_pkg::CLS_BTN1) ||
		(cls == lcsp_pkg::CLS_BTN2);
	// a result-producing item waits for the output register to free up
	assign pop = head.avail && (!is_result || !res_valid_q || !res_stall);

	assign close_val = minus_q ? (sum_q - num_q) : (sum_q + num_q);
	assign num_next  = (num_q << 3) + (num_q << 1) + VALUE_WIDTH'(code[3:0]);

	generate
		if (VALUE_WIDTH >= 32) begin : g_trunc
			assign close32 = close_val[31:0];
		end else begin : g_sext
			assign close32 = {{(32-VALUE_WIDTH){close_val[VALUE_WIDTH-1]}}, close_val};
		end
	endgenerate

	always_comb begin
		for (int k = 0; k < lcsp_pkg::NKW; k++) begin
			mismatch[k] = !((pos_q < lcsp_pkg::KW_LEN[k]) &&
				(lcsp_pkg::KW_TEXT[k][pos_q] == code));
		end
	end

	always_comb begin
		if (alive_q[lcsp_pkg::KW_LED1] && pos_q == lcsp_pkg::KW_LEN[lcsp_pkg::KW_LED1])
			kw_kind = lcsp_pkg::KIND_LED1;
		else if (alive_q[lcsp_pkg::KW_LED2] && pos_q == lcsp_pkg::KW_LEN[lcsp_pkg::KW_LED2])
			kw_kind = lcsp_pkg::KIND_LED2;
		else if (alive_q[lcsp_pkg::KW_OFF] && pos_q == lcsp_pkg::KW_LEN[lcsp_pkg::KW_OFF])
			kw_kind = lcsp_pkg::KIND_OFF;
		else if (alive_q[lcsp_pkg::KW_TOGGLE] &&
				pos_q == lcsp_pkg::KW_LEN[lcsp_pkg::KW_TOGGLE])
			kw_kind = lcsp_pkg::KIND_TOGGLE;
		else
			kw_kind = lcsp_pkg::KIND_UNKNOWN;
	end

	always_comb begin
		green_n = green_q;
		red_n   = red_q;
		sumv_n  = '0;
		kind_n  = lcsp_pkg::KIND_BUTTON;
		case (cls)
			lcsp_pkg::CLS_BTN1: begin
				green_n = 1'b1;
				red_n   = 1'b0;
			end
			lcsp_pkg::CLS_BTN2: begin
				green_n = 1'b0;
				red_n   = 1'b1;
			end
			lcsp_pkg::CLS_CR: begin
				kind_n = kw_kind;
				case (kw_kind)
					lcsp_pkg::KIND_LED1: green_n = !green_q;
					lcsp_pkg::KIND_LED2: red_n = !red_q;
					lcsp_pkg::KIND_OFF: begin
						green_n = 1'b0;
						red_n   = 1'b0;
					end
					lcsp_pkg::KIND_TOGGLE: begin
						green_n = !green_q;
						red_n   = !red_q;
					end
					default: begin
						if (!bad_q && digit_q) begin
							kind_n = lcsp_pkg::KIND_EXPR;
							sumv_n = close32;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_q <= 1'b0;
			red_q   <= 1'b0;
			pos_q   <= '0;
			alive_q <= '1;
			digit_q <= 1'b0;
			bad_q   <= 1'b0;
			minus_q <= 1'b0;
			num_q   <= '0;
			sum_q   <= '0;
		end else if (pop) begin
			green_q <= green_n;
			red_q   <= red_n;
			case (cls)
				lcsp_pkg::CLS_BTN1, lcsp_pkg::CLS_BTN2: ;
				lcsp_pkg::CLS_CR: begin
					// close the line
					pos_q   <= '0;
					alive_q <= '1;
					digit_q <= 1'b0;
					bad_q   <= 1'b0;
					minus_q <= 1'b0;
					num_q   <= '0;
					sum_q   <= '0;
				end
				default: begin
					alive_q <= alive_q & ~mismatch;
					if (pos_q != lcsp_pkg::POS_MAX)
						pos_q <= pos_q + 1'b1;
					if (cls == lcsp_pkg::CLS_DIGIT) begin
						num_q   <= num_next;
						digit_q <= 1'b1;
					end else if (cls == lcsp_pkg::CLS_PLUS || cls == lcsp_pkg::CLS_MINUS) begin
						if (!digit_q)
							bad_q <= 1'b1;
						sum_q   <= close_val;
						num_q   <= '0;
						minus_q <= (cls == lcsp_pkg::CLS_MINUS);
						digit_q <= 1'b0;
					end else begin
						bad_q <= 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (pop && is_result)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop && is_result) begin
			kind_q <= kind_n;
			sumv_q <= sumv_n;
		end
	end

	assign res_valid    = res_valid_q;
	assign command_kind = kind_q;
	assign sum_value    = sumv_q;
	assign green_on     = green_q;
	assign red_on       = red_q;

	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.avail)
		else $error("pop from empty queue");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !(pop && is_result))
		else $error("result overwritten while stalled");

	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cls == lcsp_pkg::CLS_CR) |=> (pos_q == '0 && alive_q == '1 && !bad_q))
		else $error("line state not cleared after carriage return");

	a_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && kind_q != lcsp_pkg::KIND_EXPR) |-> (sumv_q == '0))
		else $error("nonzero sum on non-expression result");

	a_button_leds: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (cls == lcsp_pkg::CLS_BTN1 || cls == lcsp_pkg::CLS_BTN2)) |=>
		(green_q != red_q))
		else $error("button left LEDs in an invalid pattern");

endmodule

/* rtl/line_command_and_sum_parser.sv */
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_type[1:0], char_code[7:0]
// res      out        res_valid/res_stall  command_kind[2:0], sum_value[31:0],
//                                          green_on, red_on
//
// One item per cycle sustained while the queue is not full and no result is held
// by res_stall; with the queue empty, an accepted item is written to the queue
// and then, once the output register is free, its result is registered there.
// Each item takes one pass through the executor; number and sum updates are
// single-step adds at VALUE_WIDTH bits.
// arst_n clears the LEDs, the line state and the four-entry queue.
// req_stall rises only when the queue is full; res_stall holds the output
// register and blocks only carriage-return and button transactions behind it.
module line_command_and_sum_parser #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic [7:0]         char_code,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         command_kind,
	output logic signed [31:0] sum_value,
	output logic               green_on,
	output logic               red_on
);

	logic               q_full;
	logic               push;
	logic               pop;
	lcsp_pkg::item_t    push_item;
	lcsp_pkg::q_head_t  head;

	lcsp_front u_front (
		.req_valid (req_valid),
		.req_type  (req_type),
		.char_code (char_code),
		.q_full    (q_full),
		.req_stall (req_stall),
		.push      (push),
		.push_item (push_item)
	);

	lcsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.head      (head)
	);

	lcsp_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.command_kind (command_kind),
		.sum_value    (sum_value),
		.green_on     (green_on),
		.red_on       (red_on)
	);

endmodule
